// File: rtl/q4q8_pkg.sv
// Shared types, constants and helper functions of the Q4 x Q8 block dot product.
`default_nettype none

package q4q8_pkg;

    localparam int unsigned QueueDepthDefault = 2;

    localparam logic [31:0] CanonNan = 32'h7FC0_0000;
    localparam logic [31:0] ExpMask  = 32'h7F80_0000;
    localparam logic [31:0] FracMask = 32'h007F_FFFF;

    // Width of the input tdata bus: all fields but last_block
    localparam int unsigned InDataW = 432;

    // One classified block handed from the front end to the back end
    typedef struct packed {
        logic [31:0]        wscale;
        logic [31:0]        ascale;
        logic signed [16:0] isum;
        logic               last;
    } q_entry_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_MULI,
        OP_ADD
    } fpu_op_t;

    typedef struct packed {
        logic        start;
        fpu_op_t     op;
        logic [31:0] a;
        logic [31:0] b;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } fpu_rsp_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Widen binary16 to binary32 exactly
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic        s;
        logic [4:0]  e;
        logic [9:0]  m;
        logic [3:0]  p;
        logic [23:0] t;
        logic [7:0]  ex;
        logic [31:0] r;
        s = h[15];
        e = h[14:10];
        m = h[9:0];
        p = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) p = i[3:0];
        end
        t = {14'b0, m} << (5'd23 - {1'b0, p});
        ex = 8'd103 + {4'b0, p};
        if (e == 5'd0) begin
            if (m == 10'd0) r = {s, 31'b0};
            else            r = {s, ex, t[22:0]};
        end else if (e == 5'h1F) begin
            r = {s, 8'hFF, m, 13'b0};
        end else begin
            r = {s, {3'b0, e} + 8'd112, m, 13'b0};
        end
        return r;
    endfunction

    // Replace any NaN by the canonical quiet NaN
    function automatic logic [31:0] canon_nan(input logic [31:0] v);
        logic [31:0] r;
        if ((v & ExpMask) == ExpMask && (v & FracMask) != 32'd0) r = CanonNan;
        else                                                     r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/q4_q8_block_dot_product.sv
// Top level of the Q4 x Q8 block dot product accumulator.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid / s_tready  s_tdata (block fields), s_tlast (last_block)
//  m_       out  m_tvalid / m_tready  m_tdata (dot_value), one per row
//
// The front end takes one block at a time (accept, two adder passes, queue push), holding
// in the push step while the queue is full. The back end pops a block, then makes three
// passes through the shared two-stage fp unit (scale multiply, multiply by the integer sum,
// accumulate); a row's last block then presents the result until it is taken.
// Reset clears the queue, the state machines and sets the accumulator to +0.
// A stalled result holds the back end; the queue lets the front end keep accepting
// until it fills.
`default_nettype none

module q4_q8_block_dot_product
    import q4q8_pkg::*;
#(
    parameter int unsigned QueueDepth = QueueDepthDefault
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // weight_scale_half, weight_nibbles_low, weight_nibbles_high, act_scale,
    // act_quants_a, act_quants_b, act_quants_c, act_quants_d
    input  wire logic [InDataW-1:0] s_tdata,
    input  wire logic               s_tlast,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // dot_value
    output logic [31:0]             m_tdata
);

    fifo_stat_t q_stat;
    logic       q_push;
    logic       q_pop;
    q_entry_t   q_wr;
    q_entry_t   q_rd;
    fpu_req_t   fpu_req;
    fpu_rsp_t   fpu_rsp;

    q4q8_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_stat.full),
        .q_push   (q_push),
        .q_data   (q_wr)
    );

    q4q8_fifo #(.Depth(QueueDepth)) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr),
        .pop     (q_pop),
        .rd_data (q_rd),
        .stat    (q_stat)
    );

    q4q8_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fpu_req),
        .rsp   (fpu_rsp)
    );

    q4q8_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_stat.empty),
        .q_data   (q_rd),
        .q_pop    (q_pop),
        .fpu_req  (fpu_req),
        .fpu_rsp  (fpu_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Never push into a full queue or pop an empty one
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_stat.full))
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) !(q_pop && q_stat.empty))
        else $error("queue underflow");

    // An fp result follows its request through the fp unit's stage registers
    assert property (@(posedge clk) disable iff (!rst_n) fpu_rsp.done |-> $past(fpu_req.start, 2))
        else $error("fp unit result without request");

    // Any NaN leaving the block is canonical
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[30:23] == 8'hFF && m_tdata[22:0] != 23'd0) |-> m_tdata == CanonNan)
        else $error("non-canonical NaN on output");

endmodule

`default_nettype wire

// File: rtl/q4q8_fifo.sv
// Short queue of classified blocks between the front end and the back end.
`default_nettype none

module q4q8_fifo
    import q4q8_pkg::*;
#(
    parameter int unsigned Depth = QueueDepthDefault
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire q_entry_t   wr_data,
    input  wire logic       pop,
    output q_entry_t        rd_data,
    output fifo_stat_t      stat
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    q_entry_t            mem_reg [Depth];
    logic [PtrW-1:0]     wr_ptr_reg;
    logic [PtrW-1:0]     rd_ptr_reg;
    logic [CntW-1:0]     count_reg;

    assign rd_data    = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CntW'(Depth));
    assign stat.empty = (count_reg == '0);

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_ptr_reg] <= wr_data;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
            end
            if (push && !pop)      count_reg <= count_reg + CntW'(1);
            else if (pop && !push) count_reg <= count_reg - CntW'(1);
        end
    end

endmodule

`default_nettype wire

// File: rtl/q4q8_front.sv
// Front end: accepts blocks, widens the weight scale and forms the exact integer dot product.
`default_nettype none

module q4q8_front
    import q4q8_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [InDataW-1:0] s_tdata,
    input  wire logic               s_tlast,
    input  wire logic               q_full,
    output logic                    q_push,
    output q_entry_t                q_data
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_SUM1,
        F_SUM2,
        F_PUSH
    } fstate_t;

    fstate_t                 state_reg;
    logic [127:0]            nib_reg;
    logic [255:0]            qnt_reg;
    logic [31:0]             ws_reg;
    logic [31:0]             as_reg;
    logic                    last_reg;
    logic signed [13:0]      part_reg [8];
    logic signed [16:0]      sum_reg;
    logic signed [13:0]      part_next [8];
    logic signed [16:0]      sum_next;

    assign s_tready = (state_reg == F_IDLE);
    assign q_push   = (state_reg == F_PUSH) && !q_full;
    assign q_data   = '{wscale: ws_reg, ascale: as_reg, isum: sum_reg, last: last_reg};

    // Four nibble-by-quant products per group
    always_comb
    begin
        for (int g = 0; g < 8; g++)
        begin
            logic signed [13:0] acc;
            acc = '0;
            for (int j = 0; j < 2; j++)
            begin
                logic [7:0]        b;
                logic signed [4:0] lo;
                logic signed [4:0] hi;
                logic signed [7:0] ql;
                logic signed [7:0] qh;
                b  = nib_reg[8*(2*g+j) +: 8];
                lo = $signed({1'b0, b[3:0]}) - 5'sd8;
                hi = $signed({1'b0, b[7:4]}) - 5'sd8;
                ql = $signed(qnt_reg[8*(2*g+j) +: 8]);
                qh = $signed(qnt_reg[8*(2*g+j+16) +: 8]);
                acc = acc + 14'(lo * ql) + 14'(hi * qh);
            end
            part_next[g] = acc;
        end
    end

    // Add the group sums
    always_comb
    begin
        sum_next = '0;
        for (int g = 0; g < 8; g++) sum_next = sum_next + 17'(part_reg[g]);
    end

    // Sequence accept, two summing passes and the queue push
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:  if (s_tvalid) state_reg <= F_SUM1;
                F_SUM1:  state_reg <= F_SUM2;
                F_SUM2:  state_reg <= F_PUSH;
                F_PUSH:  if (!q_full) state_reg <= F_IDLE;
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    // Hold the payload of the block in work
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ws_reg   <= half_to_single(s_tdata[15:0]);
            nib_reg  <= s_tdata[143:16];
            as_reg   <= s_tdata[175:144];
            qnt_reg  <= s_tdata[431:176];
            last_reg <= s_tlast;
        end
        if (state_reg == F_SUM1) part_reg <= part_next;
        if (state_reg == F_SUM2) sum_reg  <= sum_next;
    end

endmodule

`default_nettype wire

// File: rtl/q4q8_fpu.sv
// Shared two-stage binary32 unit: multiply, multiply by integer, add, round to nearest even.
`default_nettype none

module q4q8_fpu
    import q4q8_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire fpu_req_t req,
    output fpu_rsp_t      rsp
);

    logic               s1_valid_reg;
    logic               s1_special_reg;
    logic [31:0]        s1_spec_reg;
    logic               s1_sign_reg;
    logic               s1_zsign_reg;
    logic [49:0]        s1_w_reg;
    logic signed [11:0] s1_k_reg;
    logic               done_reg;
    logic [31:0]        result_reg;

    logic               special;
    logic [31:0]        spec_val;
    logic               sign;
    logic               zsign;
    logic [49:0]        w;
    logic signed [11:0] k;
    logic [31:0]        rounded;

    // Unpack, then multiply or align and add
    always_comb
    begin
        logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_big;
        logic [23:0] ma, mb, mx, my;
        logic [9:0]  ea, eb, ex, ey, d;
        logic [16:0] mag;
        logic [49:0] bf, bs;
        logic        lost;
        logic [47:0] prod;
        sa     = req.a[31];
        a_nan  = (req.a[30:23] == 8'hFF) && (req.a[22:0] != 23'd0);
        a_inf  = (req.a[30:23] == 8'hFF) && (req.a[22:0] == 23'd0);
        a_zero = (req.a[30:0] == 31'd0);
        ma     = {req.a[30:23] != 8'd0, req.a[22:0]};
        ea     = (req.a[30:23] == 8'd0) ? 10'd1 : {2'b0, req.a[30:23]};
        if (req.op == OP_MULI)
        begin
            sb     = req.b[16];
            mag    = sb ? (17'd0 - req.b[16:0]) : req.b[16:0];
            mb     = {7'b0, mag};
            eb     = 10'd150;
            b_nan  = 1'b0;
            b_inf  = 1'b0;
            b_zero = (mag == 17'd0);
        end
        else
        begin
            sb     = req.b[31];
            mag    = '0;
            mb     = {req.b[30:23] != 8'd0, req.b[22:0]};
            eb     = (req.b[30:23] == 8'd0) ? 10'd1 : {2'b0, req.b[30:23]};
            b_nan  = (req.b[30:23] == 8'hFF) && (req.b[22:0] != 23'd0);
            b_inf  = (req.b[30:23] == 8'hFF) && (req.b[22:0] == 23'd0);
            b_zero = (req.b[30:0] == 31'd0);
        end
        prod     = ma * mb;
        special  = 1'b0;
        spec_val = CanonNan;
        w        = '0;
        k        = '0;
        a_big    = (ea > eb) || (ea == eb && ma >= mb);
        mx = a_big ? ma : mb;
        my = a_big ? mb : ma;
        ex = a_big ? ea : eb;
        ey = a_big ? eb : ea;
        d  = ex - ey;
        bf = {1'b0, my, 25'b0};
        if (d >= 10'd50)
        begin
            bs   = '0;
            lost = (bf != '0);
        end
        else
        begin
            bs   = bf >> d;
            lost = |(bf & ((50'd1 << d) - 50'd1));
        end
        if (req.op == OP_ADD)
        begin
            sign  = a_big ? sa : sb;
            zsign = sa & sb;
            if (a_nan || b_nan || (a_inf && b_inf && sa != sb))
            begin
                special = 1'b1;
            end
            else if (a_inf)
            begin
                special  = 1'b1;
                spec_val = req.a;
            end
            else if (b_inf)
            begin
                special  = 1'b1;
                spec_val = req.b;
            end
            else
            begin
                w = (sa == sb) ? ({1'b0, mx, 25'b0} + (bs | 50'(lost)))
                               : ({1'b0, mx, 25'b0} - (bs | 50'(lost)));
                k = $signed({2'b0, ex}) + 12'sd1;
            end
        end
        else
        begin
            sign  = sa ^ sb;
            zsign = sign;
            if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
            begin
                special = 1'b1;
            end
            else if (a_inf || b_inf)
            begin
                special  = 1'b1;
                spec_val = {sign, 31'h7F80_0000};
            end
            else if (a_zero || b_zero)
            begin
                special  = 1'b1;
                spec_val = {sign, 31'b0};
            end
            else
            begin
                w = {prod, 2'b0};
                k = $signed({2'b0, ea}) + $signed({2'b0, eb}) - 12'sd126;
            end
        end
    end

    // Normalize, denormalize and round to nearest even
    always_comb
    begin
        logic [5:0]         lz;
        logic               found;
        logic [49:0]        wn, ws;
        logic signed [11:0] eb;
        logic [5:0]         sh;
        logic               sticky, inc;
        logic [30:0]        mag;
        lz    = '0;
        found = 1'b0;
        for (int i = 49; i >= 0; i--)
        begin
            if (!found && s1_w_reg[i])
            begin
                found = 1'b1;
                lz    = 6'(49 - i);
            end
        end
        wn = s1_w_reg << lz;
        eb = s1_k_reg - $signed({6'b0, lz});
        if (eb >= 12'sd1)        sh = '0;
        else if (eb < -12'sd61)  sh = 6'd63;
        else                     sh = 6'(12'sd1 - eb);
        ws     = wn >> sh;
        sticky = |(wn & ((50'd1 << sh) - 50'd1)) || (ws[24:0] != 25'd0);
        inc    = ws[25] && (sticky || ws[26]);
        mag    = {((eb >= 12'sd1) ? eb[7:0] : 8'd0), ws[48:26]} + 31'(inc);
        if (s1_special_reg)           rounded = s1_spec_reg;
        else if (s1_w_reg == '0)      rounded = {s1_zsign_reg, 31'b0};
        else if (eb >= 12'sd255)      rounded = {s1_sign_reg, 31'h7F80_0000};
        else                          rounded = {s1_sign_reg, mag};
    end

    // Stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req.start;
            done_reg     <= s1_valid_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        s1_special_reg <= special;
        s1_spec_reg    <= spec_val;
        s1_sign_reg    <= sign;
        s1_zsign_reg   <= zsign;
        s1_w_reg       <= w;
        s1_k_reg       <= k;
        result_reg     <= rounded;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

`default_nettype wire

// File: rtl/q4q8_back.sv
// Back end: scales each block sum and accumulates the row through the shared fp unit.
`default_nettype none

module q4q8_back
    import q4q8_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_empty,
    input  wire q_entry_t    q_data,
    output logic             q_pop,
    output fpu_req_t         fpu_req,
    input  wire fpu_rsp_t    fpu_rsp,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_ISSUE,
        B_WAIT,
        B_OUT
    } bstate_t;

    typedef enum logic [1:0] {
        STEP_SCALE,
        STEP_PROD,
        STEP_ACC
    } step_t;

    bstate_t     state_reg;
    step_t       step_reg;
    q_entry_t    item_reg;
    logic [31:0] d_reg;
    logic [31:0] p_reg;
    logic [31:0] acc_reg;
    logic [31:0] out_reg;

    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign m_tvalid = (state_reg == B_OUT);
    assign m_tdata  = out_reg;

    // Pick the operation of the current step
    always_comb
    begin
        fpu_req.start = (state_reg == B_ISSUE);
        case (step_reg)
            STEP_SCALE:
            begin
                fpu_req.op = OP_MUL;
                fpu_req.a  = item_reg.wscale;
                fpu_req.b  = item_reg.ascale;
            end
            STEP_PROD:
            begin
                fpu_req.op = OP_MULI;
                fpu_req.a  = d_reg;
                fpu_req.b  = {{15{item_reg.isum[16]}}, item_reg.isum};
            end
            default:
            begin
                fpu_req.op = OP_ADD;
                fpu_req.a  = acc_reg;
                fpu_req.b  = p_reg;
            end
        endcase
    end

    // Sequence the three operations and present the row result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg  <= STEP_SCALE;
            acc_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        step_reg  <= STEP_SCALE;
                        state_reg <= B_ISSUE;
                    end
                end
                B_ISSUE: state_reg <= B_WAIT;
                B_WAIT:
                begin
                    if (fpu_rsp.done)
                    begin
                        case (step_reg)
                            STEP_SCALE:
                            begin
                                step_reg  <= STEP_PROD;
                                state_reg <= B_ISSUE;
                            end
                            STEP_PROD:
                            begin
                                step_reg  <= STEP_ACC;
                                state_reg <= B_ISSUE;
                            end
                            default:
                            begin
                                if (item_reg.last)
                                begin
                                    acc_reg   <= '0;
                                    state_reg <= B_OUT;
                                end
                                else
                                begin
                                    acc_reg   <= fpu_rsp.result;
                                    state_reg <= B_IDLE;
                                end
                            end
                        endcase
                    end
                end
                B_OUT:   if (m_tready) state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    // Hold the block and intermediate values
    always_ff @(posedge clk)
    begin
        if (q_pop) item_reg <= q_data;
        if (state_reg == B_WAIT && fpu_rsp.done)
        begin
            if (step_reg == STEP_SCALE) d_reg <= fpu_rsp.result;
            if (step_reg == STEP_PROD)  p_reg <= fpu_rsp.result;
            if (step_reg == STEP_ACC)   out_reg <= canon_nan(fpu_rsp.result);
        end
    end

endmodule

`default_nettype wire
